// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fbb_pkg.sv =====
// types and constants shared by the foreground bounding box files
`default_nettype none

package fbb_pkg;

	localparam int RGB_W = 24;
	localparam int DIM_CFG_W = 13;
	localparam int BOX_W = 12;

	localparam logic [RGB_W-1:0] PAPER_COLOR_RESET = 24'hFFFFFF;
	localparam logic [DIM_CFG_W-1:0] FRAME_DIM_RESET = 13'd4096;

	typedef enum logic [1:0] {
		REG_PAPER_COLOR,
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT
	} reg_idx_t;

	typedef struct packed {
		logic blank;
		logic [BOX_W-1:0] left;
		logic [BOX_W-1:0] top;
		logic [BOX_W-1:0] right;
		logic [BOX_W-1:0] bottom;
	} box_result_t;

endpackage

`default_nettype wire

// ===== rtl/fbb_tracker.sv =====
// raster position counters and content bounds tracking for one frame
`default_nettype none

module fbb_tracker import fbb_pkg::*; #(
	parameter int MAX_DIMENSION = 4096
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire logic content,
	input  wire logic [DIM_CFG_W-1:0] frame_width,
	input  wire logic [DIM_CFG_W-1:0] frame_height,
	output logic frame_end,
	output box_result_t result
);

	localparam int DIM_W = $clog2(MAX_DIMENSION);
	localparam int WW = ((DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W) + 1;
	localparam int EW = (DIM_W > BOX_W) ? DIM_W : BOX_W;
	localparam logic [WW-1:0] MAX_W = WW'(MAX_DIMENSION);
	localparam logic [WW-1:0] ONE_W = WW'(1);

	logic [DIM_W-1:0] col_q, row_q;
	logic [DIM_W-1:0] min_col_q, max_col_q, min_row_q, max_row_q;
	logic seen_q;

	logic [WW-1:0] width_w, height_w, clamp_w, clamp_h, last_col, last_row;
	logic row_end;
	logic [DIM_W-1:0] nb_min_col, nb_max_col, nb_min_row, nb_max_row;
	logic nb_seen;
	logic [EW-1:0] ext_l, ext_t, ext_r, ext_b;

	// dimension clamp: zero counts as one, oversize counts as the maximum
	always_comb begin
		width_w = WW'(frame_width);
		height_w = WW'(frame_height);
		clamp_w = width_w;
		if (width_w == '0) begin
			clamp_w = ONE_W;
		end else if (width_w > MAX_W) begin
			clamp_w = MAX_W;
		end
		clamp_h = height_w;
		if (height_w == '0) begin
			clamp_h = ONE_W;
		end else if (height_w > MAX_W) begin
			clamp_h = MAX_W;
		end
		last_col = clamp_w - ONE_W;
		last_row = clamp_h - ONE_W;
	end

	assign row_end = WW'(col_q) >= last_col;
	assign frame_end = row_end && (WW'(row_q) >= last_row);

	// bounds including the pixel now in the stage
	always_comb begin
		nb_min_col = min_col_q;
		nb_max_col = max_col_q;
		nb_min_row = min_row_q;
		nb_max_row = max_row_q;
		nb_seen = seen_q;
		if (content) begin
			nb_seen = 1'b1;
			if (!seen_q) begin
				nb_min_col = col_q;
				nb_max_col = col_q;
				nb_min_row = row_q;
				nb_max_row = row_q;
			end else begin
				if (col_q < min_col_q) nb_min_col = col_q;
				if (col_q > max_col_q) nb_max_col = col_q;
				if (row_q < min_row_q) nb_min_row = row_q;
				if (row_q > max_row_q) nb_max_row = row_q;
			end
		end
	end

	assign ext_l = EW'(nb_min_col);
	assign ext_t = EW'(nb_min_row);
	assign ext_r = EW'(nb_max_col);
	assign ext_b = EW'(nb_max_row);

	always_comb begin
		result.blank = !nb_seen;
		result.left = nb_seen ? ext_l[BOX_W-1:0] : '0;
		result.top = nb_seen ? ext_t[BOX_W-1:0] : '0;
		result.right = nb_seen ? ext_r[BOX_W-1:0] : '0;
		result.bottom = nb_seen ? ext_b[BOX_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			min_col_q <= '0;
			max_col_q <= '0;
			min_row_q <= '0;
			max_row_q <= '0;
			seen_q <= 1'b0;
		end else if (step) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
				min_col_q <= '0;
				max_col_q <= '0;
				min_row_q <= '0;
				max_row_q <= '0;
				seen_q <= 1'b0;
			end else begin
				min_col_q <= nb_min_col;
				max_col_q <= nb_max_col;
				min_row_q <= nb_min_row;
				max_row_q <= nb_max_row;
				seen_q <= nb_seen;
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + DIM_W'(1);
				end else begin
					col_q <= col_q + DIM_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/foreground_bounding_box.sv =====
// foreground bounding box: the frame result is registered when the frame's last pixel leaves the input stage
// throughput one pixel per cycle, stalls only when a frame result waits on out_ready
// one result transaction per frame, issued with the frame's last pixel
// reset (arst_n low, asynchronous) clears the counters, bounds and valid flags
// and returns the registers to paper white and a 4096 by 4096 frame
`default_nettype none

module foreground_bounding_box import fbb_pkg::*; #(
	parameter int MAX_DIMENSION = 4096
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// apb register port
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [3:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// pixel stream
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [31:0] pixel_argb,
	// frame result
	output logic out_valid,
	input  wire logic out_ready,
	output logic blank,
	output logic [BOX_W-1:0] box_left,
	output logic [BOX_W-1:0] box_top,
	output logic [BOX_W-1:0] box_right,
	output logic [BOX_W-1:0] box_bottom
);

	// configuration registers
	logic [RGB_W-1:0] paper_q;
	logic [DIM_CFG_W-1:0] width_q;
	logic [DIM_CFG_W-1:0] height_q;
	reg_idx_t reg_idx;
	logic cfg_write;

	// input stage holds one pixel, only the rgb part matters
	logic valid_s1;
	logic [RGB_W-1:0] rgb_s1;

	// result register
	logic out_valid_q;
	box_result_t res_q;

	logic step;
	logic frame_end;
	logic content;
	box_result_t result;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paper_q <= PAPER_COLOR_RESET;
			width_q <= FRAME_DIM_RESET;
			height_q <= FRAME_DIM_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_PAPER_COLOR: paper_q <= pwdata[RGB_W-1:0];
				REG_FRAME_WIDTH: width_q <= pwdata[DIM_CFG_W-1:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[DIM_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux, unused address reads as zero
	always_comb begin
		case (reg_idx)
			REG_PAPER_COLOR: prdata = 32'(paper_q);
			REG_FRAME_WIDTH: prdata = 32'(width_q);
			REG_FRAME_HEIGHT: prdata = 32'(height_q);
			default: prdata = '0;
		endcase
	end

	// the staged pixel moves on unless it ends a frame and the result
	// register is still holding an untaken result
	assign content = rgb_s1 != paper_q;
	assign step = valid_s1 && (!frame_end || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rgb_s1 <= pixel_argb[RGB_W-1:0];
		end
	end

	fbb_tracker #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_tracker (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.content(content),
		.frame_width(width_q),
		.frame_height(height_q),
		.frame_end(frame_end),
		.result(result)
	);

	// result register: loaded by the frame's last pixel, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && frame_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && frame_end) begin
			res_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign blank = res_q.blank;
	assign box_left = res_q.left;
	assign box_top = res_q.top;
	assign box_right = res_q.right;
	assign box_bottom = res_q.bottom;

endmodule

`default_nettype wire

// ===== rtl/fbb_checker.sv =====
// port-level checker for the foreground bounding box, with its bind
`default_nettype none
`include "assert_macros.svh"

module fbb_port_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pready,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic blank,
	input wire logic [11:0] box_left,
	input wire logic [11:0] box_top,
	input wire logic [11:0] box_right,
	input wire logic [11:0] box_bottom
);

	// a blank frame reports an all-zero box
	`ASSERT_IMPLIES(a_blank_zero, clk, arst_n, out_valid && blank, box_left == 12'd0 && box_top == 12'd0 && box_right == 12'd0 && box_bottom == 12'd0, "blank result with nonzero box")

	// with no result pending the pixel side never stalls
	`ASSERT_IMPLIES(a_ready_when_empty, clk, arst_n, !out_valid, in_ready, "pixel input stalled with empty result register")

	// register port never inserts wait states
	`ASSERT_IMPLIES(a_pready_high, clk, arst_n, 1'b1, pready, "pready dropped")

	// a stalled result transaction holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(blank) && $stable(box_left) && $stable(box_top) && $stable(box_right) && $stable(box_bottom), "result changed while stalled")

endmodule

bind foreground_bounding_box fbb_port_checker u_fbb_checker (.*);

`default_nettype wire
